>>> hw/rtl/sha1md_pkg.sv
`timescale 1ns / 1ps

package sha1md_pkg;

    typedef logic [4:0][31:0] chain_t;

    localparam chain_t SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_CH     = 32'h5A827999;
    localparam logic [31:0] K_PAR_LO = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ    = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR_HI = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_PAD,
        ST_FINISH
    } top_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_LOAD,
        CORE_ROUND,
        CORE_DONE
    } core_state_t;

    typedef struct packed {
        logic   done;
        chain_t vars;
    } core_status_t;

    function automatic logic [31:0] round_f(
        input logic [6:0]  t,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] r;
        if (t < 7'd20)
            r = (b & c) | (~b & d);
        else if (t < 7'd40)
            r = b ^ c ^ d;
        else if (t < 7'd60)
            r = (b & c) | (b & d) | (c & d);
        else
            r = b ^ c ^ d;
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] r;
        if (t < 7'd20)
            r = K_CH;
        else if (t < 7'd40)
            r = K_PAR_LO;
        else if (t < 7'd60)
            r = K_MAJ;
        else
            r = K_PAR_HI;
        return r;
    endfunction

endpackage

>>> hw/rtl/sha1md_ram.sv
`timescale 1ns / 1ps

module sha1md_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/sha1md_core.sv
`timescale 1ns / 1ps

module sha1md_core
    import sha1md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  chain_t       chain,
    output logic [3:0]   rd_addr,
    input  logic [31:0]  rd_data,
    output core_status_t status
);

    core_state_t state_reg, state_next;
    logic [6:0]  round_reg, round_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [31:0] win_reg [16];
    logic [31:0] x_sched, w_cur, temp;
    logic        load, step;

    // schedule window: win_reg[15] newest
    assign x_sched = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur   = (round_reg < 7'd16) ? rd_data : {x_sched[30:0], x_sched[31]};
    assign temp    = {a_reg[26:0], a_reg[31:27]} + round_f(round_reg, b_reg, c_reg, d_reg)
                   + e_reg + round_k(round_reg) + w_cur;

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        load       = 1'b0;
        step       = 1'b0;
        rd_addr    = round_reg[3:0] + 4'd1;
        status     = '{done: 1'b0, vars: {e_reg, d_reg, c_reg, b_reg, a_reg}};
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (start)
                begin
                    state_next = CORE_LOAD;
                end
            end
            CORE_LOAD:
            begin
                rd_addr    = 4'd0;
                load       = 1'b1;
                round_next = 7'd0;
                state_next = CORE_ROUND;
            end
            CORE_ROUND:
            begin
                step       = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = CORE_DONE;
                end
            end
            CORE_DONE:
            begin
                status.done = 1'b1;
                state_next  = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (load)
        begin
            a_next = chain[0];
            b_next = chain[1];
            c_next = chain[2];
            d_next = chain[3];
            e_next = chain[4];
        end
        else if (step)
        begin
            a_next = temp;
            b_next = a_reg;
            c_next = {b_reg[1:0], b_reg[31:2]};
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        if (step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_cur;
        end
    end

endmodule

>>> hw/rtl/sha1_message_digest.sv
`timescale 1ns / 1ps

// SHA-1 hash of a byte stream. Each input word carries one message byte in
// s_tdata when s_tuser is set; s_tlast closes the message, with or without a
// byte, so an empty message is legal. Bytes are taken one per cycle, while
// s_tready is high, into a 16x32 block RAM. Every 64th byte starts a
// compression that holds off input: a RAM load, 80 rounds at one round per
// cycle, and a fold of the result into the chaining words. On the closing
// word the padding is written one byte per cycle with one or two further
// compressions, then the five digest words leave on m_tdata, h0 first, with
// m_tuser giving the word index and m_tlast on the fifth. The digest sits in
// its own output register, so the next message can start while it is
// drained.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    top_state_t   state_reg, state_next;
    chain_t       chain_reg, chain_next;
    logic [5:0]   pos_reg, pos_next;
    logic [63:0]  len_reg, len_next;
    logic [23:0]  acc_reg, acc_next;
    logic         pad_reg, pad_next;
    logic         marker_reg, marker_next;
    logic         len_ok_reg, len_ok_next;
    logic         final_reg, final_next;
    chain_t       out_words_reg, out_words_next;
    logic         out_valid_reg, out_valid_next;
    logic [2:0]   out_idx_reg, out_idx_next;

    logic         inj_en, wrap, core_start;
    logic [7:0]   inj_byte, len_byte;
    logic         ram_we;
    logic [31:0]  ram_wdata, ram_rdata;
    logic [3:0]   ram_raddr;
    core_status_t core_stat;

    sha1md_ram #(
        .WIDTH(32),
        .DEPTH(16)
    ) u_block_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pos_reg[5:2]),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    sha1md_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (core_start),
        .chain  (chain_reg),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata),
        .status (core_stat)
    );

    assign len_byte  = len_reg[{~pos_reg[2:0], 3'b000} +: 8];
    assign ram_wdata = {acc_reg, inj_byte};
    assign ram_we    = inj_en && (pos_reg[1:0] == 2'b11);
    assign wrap      = inj_en && (pos_reg == LAST_POS);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_words_reg[0];
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == LAST_INDEX);

    always_comb
    begin
        state_next     = state_reg;
        chain_next     = chain_reg;
        len_next       = len_reg;
        pad_next       = pad_reg;
        marker_next    = marker_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        out_words_next = out_words_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        s_tready       = 1'b0;
        inj_en         = 1'b0;
        inj_byte       = 8'h00;
        core_start     = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_words_next = out_words_reg >> 32;
            out_idx_next   = out_idx_reg + 3'd1;
            if (out_idx_reg == LAST_INDEX)
            begin
                out_valid_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    pad_next = s_tlast;
                    if (s_tuser[0])
                    begin
                        inj_en   = 1'b1;
                        inj_byte = s_tdata;
                        len_next = len_reg + 64'd8;
                    end
                    if (s_tuser[0] && (pos_reg == LAST_POS))
                    begin
                        core_start = 1'b1;
                        state_next = ST_HASH;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                inj_en = 1'b1;
                if (!marker_reg)
                begin
                    inj_byte = PAD_MARKER;
                end
                else if (len_ok_reg && (pos_reg >= LEN_POS))
                begin
                    inj_byte = len_byte;
                end
                marker_next = 1'b1;
                if (!marker_reg && (pos_reg < LEN_POS))
                begin
                    len_ok_next = 1'b1;
                end
                if (wrap)
                begin
                    core_start  = 1'b1;
                    final_next  = len_ok_reg;
                    len_ok_next = 1'b1;
                    state_next  = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (core_stat.done)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_next[i] = chain_reg[i] + core_stat.vars[i];
                    end
                    if (final_reg)
                        state_next = ST_FINISH;
                    else if (pad_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg)
                begin
                    out_words_next = chain_reg;
                    out_valid_next = 1'b1;
                    out_idx_next   = 3'd0;
                    chain_next     = SHA1_IV;
                    len_next       = '0;
                    pad_next       = 1'b0;
                    marker_next    = 1'b0;
                    len_ok_next    = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        pos_next = inj_en ? pos_reg + 6'd1 : pos_reg;
        acc_next = inj_en ? {acc_reg[15:0], inj_byte} : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chain_reg     <= SHA1_IV;
            pos_reg       <= '0;
            len_reg       <= '0;
            pad_reg       <= 1'b0;
            marker_reg    <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chain_reg     <= chain_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            pad_reg       <= pad_next;
            marker_reg    <= marker_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        out_words_reg <= out_words_next;
    end

endmodule

>>> tb/sv/tb_sha1_message_digest.sv
`timescale 1ns / 1ps

module tb_sha1_message_digest;
    import sha1md_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    class digest_tracker;
        chain_t        h;
        logic [7:0]    blk [64];
        int            fill;
        logic [63:0]   bit_len;
        digest_out_t   expected_q [$];
        int            n_errors;

        function new();
            h = SHA1_IV;
            fill = 0;
            bit_len = '0;
            n_errors = 0;
            foreach (blk[i])
                blk[i] = 8'h00;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            n_errors++;
        endtask

        function void compress_block();
            logic [31:0] w [16];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            a = h[0];
            b = h[1];
            c = h[2];
            d = h[3];
            e = h[4];
            for (int i = 0; i < 80; i++)
            begin
                if (i >= 16)
                begin
                    x = w[(i-3) & 15] ^ w[(i-8) & 15] ^ w[(i-14) & 15] ^ w[i & 15];
                    w[i & 15] = {x[30:0], x[31]};
                end
                if (i < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K_CH;
                end
                else if (i < 40)
                begin
                    f = b ^ c ^ d;
                    k = K_PAR_LO;
                end
                else if (i < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K_PAR_HI;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[i & 15];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            h[0] = h[0] + a;
            h[1] = h[1] + b;
            h[2] = h[2] + c;
            h[3] = h[3] + d;
            h[4] = h[4] + e;
        endfunction

        function void absorb_word(input logic [7:0] data, input logic has, input logic eom);
            digest_out_t o;
            if (has)
            begin
                blk[fill] = data;
                bit_len = bit_len + 64'd8;
                fill++;
                if (fill == 64)
                begin
                    compress_block();
                    fill = 0;
                end
            end
            if (!eom)
                return;
            blk[fill] = PAD_MARKER;
            fill++;
            if (fill > int'(LEN_POS))
            begin
                while (fill < 64)
                begin
                    blk[fill] = 8'h00;
                    fill++;
                end
                compress_block();
                fill = 0;
            end
            while (fill < int'(LEN_POS))
            begin
                blk[fill] = 8'h00;
                fill++;
            end
            for (int j = 0; j < 8; j++)
                blk[int'(LEN_POS) + j] = bit_len[63 - 8*j -: 8];
            compress_block();
            for (int j = 0; j < 5; j++)
            begin
                o.digest_word = h[j];
                o.word_index = 3'(j);
                o.last_word = (3'(j) == LAST_INDEX);
                expected_q.push_back(o);
            end
            h = SHA1_IV;
            fill = 0;
            bit_len = '0;
        endfunction

        task check_digest_word(input logic [31:0] dw, input logic [2:0] idx, input logic lst);
            digest_out_t o;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word %08h idx %0d last %0b", dw, idx, lst));
                return;
            end
            o = expected_q.pop_front();
            if (dw !== o.digest_word)
                report_mismatch($sformatf("digest word idx %0d: got %08h exp %08h",
                                          o.word_index, dw, o.digest_word));
            if (idx !== o.word_index)
                report_mismatch($sformatf("word index: got %0d exp %0d", idx, o.word_index));
            if (lst !== o.last_word)
                report_mismatch($sformatf("last flag idx %0d: got %0b exp %0b",
                                          o.word_index, lst, o.last_word));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [0:0]  s_tuser;   // [0] has_byte
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] digest_word
    logic [2:0]  m_tuser;   // [2:0] word_index
    logic        m_tlast;

    digest_tracker sb;
    int            cycle_count;
    int            tx_calm_left;
    int            rx_calm_left;
    int            rx_hold;
    int            n_items;
    int            n_messages;

    sha1_message_digest u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_digest_word(m_tdata, m_tuser, m_tlast);
    end

    // sink stalls: mostly short, a few long, with calm stretches
    initial
    begin
        m_tready = 1'b0;
        rx_hold = 0;
        rx_calm_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready = 1'b0;
                rx_hold--;
            end
            else
            begin
                int r;
                m_tready = 1'b1;
                r = $urandom_range(199);
                if (rx_calm_left > 0)
                    rx_calm_left--;
                else if (r < 30)
                    rx_hold = $urandom_range(1, 3);
                else if (r < 36)
                    rx_hold = $urandom_range(10, 40);
                else if (r < 38)
                    rx_calm_left = $urandom_range(50, 200);
            end
        end
    end

    task automatic send_word(input logic [7:0] b, input logic has, input logic eom);
        int r;
        int gap;
        r = $urandom_range(99);
        gap = 0;
        if (tx_calm_left > 0)
            tx_calm_left--;
        else if (r < 20)
            gap = $urandom_range(1, 3);
        else if (r < 24)
            gap = $urandom_range(8, 40);
        else if (r < 26)
            tx_calm_left = $urandom_range(30, 120);
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom);
            s_tuser = 1'($urandom);
            s_tlast = 1'($urandom);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = b;
        s_tuser = has;
        s_tlast = eom;
        do
            @(posedge clk);
        while (!s_tready);
        sb.absorb_word(b, has, eom);
        n_items++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // idle words are ignored by the block
    task automatic send_message(input int len, input bit bare_end);
        bit use_bare;
        use_bare = bare_end || (len == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom_range(255)), 1'b1, !use_bare && (i == len - 1));
        end
        if (use_bare)
        begin
            send_word(8'($urandom), 1'b0, 1'b1);
        end
        n_messages++;
    endtask

    initial
    begin
        int boundary_len [8];
        int r;
        int len;
        boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
        sb = new();
        cycle_count = 0;
        tx_calm_left = 0;
        n_items = 0;
        n_messages = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message
        send_word(8'hA5, 1'b0, 1'b1);
        // "abc"
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // idle words, then one zero byte closing the message
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        // bytes closed by a bare end, idle word in between
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7F, 1'b1, 1'b1);
        hold_until_drained();

        while (n_items < 240 || n_messages < 6)
        begin
            r = $urandom_range(99);
            if (r < 55)
                len = $urandom_range(0, 8);
            else if (r < 75)
                len = boundary_len[$urandom_range(7)];
            else
                len = $urandom_range(9, 70);
            send_message(len, $urandom_range(3) == 0);
            if ($urandom_range(7) == 0)
                hold_until_drained();
        end
        @(negedge clk);
        s_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
